@@ hdl/hnfr_pkg.sv @@
// Shared types, codeword table and CRC-16 step for the Hamming nibble frame receiver.
package hnfr_pkg;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_BYTE  = 2'd1,
        KIND_STOP  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_STARTED = 3'd1,
        ST_RUNNING = 3'd2,
        ST_OK      = 3'd3,
        ST_HAMERR  = 3'd4,
        ST_CRCERR  = 3'd5,
        ST_STOPPED = 3'd6
    } status_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] nibble;
    } nib_dec_t;

    localparam logic [7:0] CODEWORDS [16] = '{
        8'h15, 8'h02, 8'h49, 8'h5E, 8'h64, 8'h73, 8'h38, 8'h2F,
        8'hD0, 8'hC7, 8'h8C, 8'h9B, 8'hA1, 8'hB6, 8'hFD, 8'hEA
    };

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int n = 0; n < 8; n++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

@@ hdl/hnfr_radio_if.sv @@
// Request channel that carries start, stop and raw radio byte requests.
interface hnfr_radio_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] radio_byte;

    modport source (output valid, output kind, output radio_byte, input ready);
    modport sink   (input valid, input kind, input radio_byte, output ready);
endinterface

@@ hdl/hnfr_result_if.sv @@
// Result channel that carries one decoded byte and frame status per request.
interface hnfr_result_if;
    logic       valid;
    logic       ready;
    logic       byte_valid;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [2:0] status;
    logic       frame_end;

    modport source (output valid, output byte_valid, output payload_byte,
                    output byte_index, output status, output frame_end, input ready);
    modport sink   (input valid, input byte_valid, input payload_byte,
                    input byte_index, input status, input frame_end, output ready);
endinterface

@@ hdl/hamming_nibble_frame_receiver.sv @@
// Top level of the Hamming nibble frame receiver with CRC-16 frame check.
// An accepted request has its result registered and valid in the following cycle.
// Throughput: one request per cycle; the single result register is refilled in the
// same cycle it is taken, so only a stalled result sink holds off new requests.
// Reset (rst_n, asynchronous, active low) puts the receiver idle with the frame
// state cleared, last index at BUFFER_SIZE, CRC at 0xFFFF and the result register empty.
module hamming_nibble_frame_receiver #(
    parameter int BUFFER_SIZE = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    hnfr_radio_if.sink           radio,
    hnfr_result_if.source        result
);
    import hnfr_pkg::*;

    // The write index runs one past the last index, which never exceeds BUFFER_SIZE.
    localparam int WI_W  = $clog2(BUFFER_SIZE + 2);
    localparam int LI_W  = $clog2(BUFFER_SIZE + 1);
    localparam int CMP_W = WI_W + 1;
    localparam logic [7:0] BUF_MAX = 8'(BUFFER_SIZE);

    // Frame state.
    logic            receive_active_reg, receive_active_next;
    logic            low_half_next_reg, low_half_next_next;
    logic [3:0]      high_nibble_reg, high_nibble_next;
    logic [WI_W-1:0] write_index_reg, write_index_next;
    logic [LI_W-1:0] last_index_reg, last_index_next;
    logic [15:0]     crc_reg, crc_next;
    logic [7:0]      crc_high_reg, crc_high_next;
    status_t         status_reg, status_next;

    // Result register.
    logic            out_valid_reg, out_valid_next;
    logic            byte_valid_reg, byte_valid_next;
    logic [7:0]      payload_reg, payload_next;
    logic [6:0]      index_reg, index_next;
    logic            frame_end_reg, frame_end_next;

    logic            accept;
    nib_dec_t        dec;
    logic [7:0]      assembled;
    logic [LI_W-1:0] last_eff;
    logic [CMP_W-1:0] i_ext;
    logic [CMP_W-1:0] l_ext;
    logic [15:0]     index_wide;

    hnfr_nibble_decoder u_decoder (
        .code (radio.radio_byte),
        .dec  (dec)
    );

    // A new request is taken whenever the result register is empty or being drained.
    assign radio.ready = !out_valid_reg || result.ready;
    assign accept      = radio.valid && radio.ready;

    assign assembled  = {high_nibble_reg, dec.nibble};
    assign i_ext      = CMP_W'(write_index_reg);
    assign index_wide = {{(16 - WI_W){1'b0}}, write_index_reg};

    // Byte 2 carries the index of the frame's last byte; it takes effect for the comparisons of the
    // same byte, clamped to the buffer size.
    always_comb
    begin
        if (write_index_reg == WI_W'(2))
        begin
            last_eff = (assembled > BUF_MAX) ? LI_W'(BUF_MAX) : LI_W'(assembled);
        end
        else
        begin
            last_eff = last_index_reg;
        end
    end

    assign l_ext = CMP_W'(last_eff);

    // Next frame state and result payload for the accepted request.
    always_comb
    begin
        receive_active_next = receive_active_reg;
        low_half_next_next  = low_half_next_reg;
        high_nibble_next    = high_nibble_reg;
        write_index_next    = write_index_reg;
        last_index_next     = last_index_reg;
        crc_next            = crc_reg;
        crc_high_next       = crc_high_reg;
        status_next         = status_reg;
        byte_valid_next     = 1'b0;
        payload_next        = 8'h00;
        index_next          = 7'd0;
        frame_end_next      = 1'b0;

        if (accept)
        begin
            unique case (kind_t'(radio.kind))
                KIND_START:
                begin
                    // A start always restarts the frame from scratch.
                    receive_active_next = 1'b1;
                    low_half_next_next  = 1'b0;
                    high_nibble_next    = 4'h0;
                    write_index_next    = '0;
                    last_index_next     = LI_W'(BUF_MAX);
                    crc_next            = CRC_INIT;
                    crc_high_next       = 8'h00;
                    status_next         = ST_STARTED;
                end
                KIND_STOP:
                begin
                    receive_active_next = 1'b0;
                    status_next         = ST_STOPPED;
                end
                KIND_BYTE:
                begin
                    if (receive_active_reg)
                    begin
                        status_next = ST_RUNNING;
                        if (!dec.hit)
                        begin
                            status_next         = ST_HAMERR;
                            receive_active_next = 1'b0;
                            frame_end_next      = 1'b1;
                        end
                        else if (!low_half_next_reg)
                        begin
                            high_nibble_next   = dec.nibble;
                            low_half_next_next = 1'b1;
                        end
                        else
                        begin
                            low_half_next_next = 1'b0;
                            byte_valid_next    = 1'b1;
                            payload_next       = assembled;
                            index_next         = index_wide[6:0];
                            last_index_next    = last_eff;
                            write_index_next   = write_index_reg + WI_W'(1);
                            // Bytes up to last-2 feed the CRC; byte last-1 is the
                            // received CRC high byte; byte last closes the frame.
                            if (i_ext + CMP_W'(2) <= l_ext)
                            begin
                                crc_next = crc16_byte(crc_reg, assembled);
                            end
                            else if (i_ext + CMP_W'(1) == l_ext)
                            begin
                                crc_high_next = assembled;
                            end
                            if (i_ext + CMP_W'(1) > l_ext)
                            begin
                                // Too short a frame has no CRC to check.
                                if (last_eff < LI_W'(4))
                                begin
                                    status_next = ST_CRCERR;
                                end
                                else if (crc_high_reg == crc_reg[15:8] &&
                                         assembled == crc_reg[7:0])
                                begin
                                    status_next = ST_OK;
                                end
                                else
                                begin
                                    status_next = ST_CRCERR;
                                end
                                receive_active_next = 1'b0;
                                frame_end_next      = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    // Unused request code: gives a result with no byte and leaves the frame state unchanged.
                end
            endcase
        end
    end

    always_comb
    begin
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_active_reg <= 1'b0;
            low_half_next_reg  <= 1'b0;
            high_nibble_reg    <= 4'h0;
            write_index_reg    <= '0;
            last_index_reg     <= LI_W'(BUF_MAX);
            crc_reg            <= CRC_INIT;
            crc_high_reg       <= 8'h00;
            status_reg         <= ST_IDLE;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            receive_active_reg <= receive_active_next;
            low_half_next_reg  <= low_half_next_next;
            high_nibble_reg    <= high_nibble_next;
            write_index_reg    <= write_index_next;
            last_index_reg     <= last_index_next;
            crc_reg            <= crc_next;
            crc_high_reg       <= crc_high_next;
            status_reg         <= status_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    // Result payload is loaded only with an accepted request and needs no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_valid_reg <= byte_valid_next;
            payload_reg    <= payload_next;
            index_reg      <= index_next;
            frame_end_reg  <= frame_end_next;
        end
    end

    // The reported status is the frame status after the request.
    assign result.valid        = out_valid_reg;
    assign result.byte_valid   = byte_valid_reg;
    assign result.payload_byte = payload_reg;
    assign result.byte_index   = index_reg;
    assign result.status       = status_reg;
    assign result.frame_end    = frame_end_reg;

    // Every accepted request produces a result in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result.valid)
        else $error("accepted request produced no result");

    // A frame end carries one of the final statuses.
    a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.frame_end) |->
        (status_reg == ST_OK || status_reg == ST_HAMERR || status_reg == ST_CRCERR))
        else $error("frame end without final status");

    // Reception only stops through a stop request or a finished frame.
    a_active_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(receive_active_reg) |->
        (status_reg == ST_OK || status_reg == ST_HAMERR ||
         status_reg == ST_CRCERR || status_reg == ST_STOPPED))
        else $error("reception ended without final or stopped status");

endmodule

@@ hdl/hnfr_nibble_decoder.sv @@
// Hamming codeword lookup: maps a radio byte to its nibble or flags a non-codeword.
module hnfr_nibble_decoder (
    input  logic [7:0]         code,
    output hnfr_pkg::nib_dec_t dec
);
    import hnfr_pkg::*;

    // Codewords are distinct, so at most one entry matches and the OR is exact.
    always_comb
    begin
        dec = '0;
        for (int k = 0; k < 16; k++)
        begin
            if (code == CODEWORDS[k])
            begin
                dec.hit    = 1'b1;
                dec.nibble = dec.nibble | 4'(k);
            end
        end
    end
endmodule
